// ===== rtl/text_console_char_writer_macros.svh =====
// Assertion macros for the text console character writer.
// Included by the top level; depends on nothing else.
// Defining NO_ASSERTIONS leaves every macro empty.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held.
`define TCW_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define TCW_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
// Used by the controller, the datapath and the top level; no dependencies.
package tcw_pkg;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = ATTR_W + CHAR_W;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;        // act on the item being accepted
        logic prime;       // first read of the scroll copy
        logic scroll;      // one step of the scroll copy
        logic blank;       // one step of a blanking sweep
        logic blank_init;  // blank with the reset attribute
        logic load_result; // move the result into the output register
    } tcw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exec_scroll; // the item being accepted scrolls the grid
        logic exec_clear;  // the item being accepted clears the grid
        logic sweep_last;  // the sweep counter is on the last cell
        logic out_free;    // the output register can take a result
    } tcw_status_t;

endpackage

// ===== rtl/tcw_datapath.sv =====
// Datapath of the text console character writer: cell memory, cursor,
// sweep counter, attribute register and output register.
// Depends on tcw_pkg; driven by tcw_ctrl through tcw_cmd_t.
module tcw_datapath #(
    parameter int NUM_COLUMNS = 80,
    parameter int NUM_ROWS    = 25,
    parameter int TAB_STOP    = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tcw_pkg::tcw_cmd_t                  cmd,
    output tcw_pkg::tcw_status_t               status,
    input  logic [tcw_pkg::OP_W-1:0]           opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
    input  logic [tcw_pkg::IDX_W-1:0]          cell_index,
    input  logic                               cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]         cfg_wr_data,
    input  logic                               m_tready,
    output logic                               m_valid,
    output logic [tcw_pkg::POS_W-1:0]          cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]         cell_value
);

    localparam int GRID       = NUM_ROWS * NUM_COLUMNS;
    localparam int COPY_CELLS = GRID - NUM_COLUMNS;
    localparam int ADDR_W     = $clog2(GRID);
    localparam int COL_W      = $clog2(NUM_COLUMNS);
    localparam int COLX_W     = $clog2(NUM_COLUMNS + TAB_STOP);
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int ROWX_W     = $clog2(NUM_ROWS + 1);
    localparam int PH_W       = $clog2(TAB_STOP);
    localparam int CMP_W      = (ADDR_W > tcw_pkg::IDX_W) ? ADDR_W : tcw_pkg::IDX_W;
    localparam int LAST_PH    = (NUM_COLUMNS - 1) % TAB_STOP;

    logic [tcw_pkg::CELL_W-1:0] mem [GRID];
    logic [tcw_pkg::CELL_W-1:0] mem_q_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;

    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [PH_W-1:0]            phase_reg, phase_next;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic [ADDR_W-1:0]          sweep_reg, sweep_next;
    logic                       rd_hit_reg, rd_hit_next;
    logic                       m_valid_reg, m_valid_next;
    logic [tcw_pkg::POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [tcw_pkg::CELL_W-1:0] m_cell_reg, m_cell_next;

    logic [COLX_W-1:0]          col_x;
    logic [ROWX_W-1:0]          row_x;
    logic [PH_W-1:0]            ph_x;
    logic                       need_scroll;
    logic                       printable;
    logic                       is_write;
    logic                       idx_hit;
    logic                       sweep_last;
    logic [ADDR_W-1:0]          cur_lin;

    assign is_write   = (opcode == tcw_pkg::OP_WRITE);
    assign printable  = !char_code[7] && (char_code[6:5] != 2'b00);
    assign idx_hit    = CMP_W'(cell_index) < CMP_W'(GRID);
    assign sweep_last = (sweep_reg == ADDR_W'(GRID - 1));
    assign cur_lin    = ADDR_W'(row_reg) * ADDR_W'(NUM_COLUMNS) + ADDR_W'(col_reg);

    // Cursor after one character; the phase register tracks column modulo TAB_STOP.
    always_comb begin
        col_x       = COLX_W'(col_reg);
        row_x       = ROWX_W'(row_reg);
        ph_x        = phase_reg;
        need_scroll = 1'b0;
        priority if (char_code == tcw_pkg::CH_LF) begin
            col_x = '0;
            row_x = row_x + ROWX_W'(1);
            ph_x  = '0;
        end else if (char_code == tcw_pkg::CH_BS) begin
            if (col_reg != '0) begin
                col_x = col_x - COLX_W'(1);
                ph_x  = (phase_reg == '0) ? PH_W'(TAB_STOP - 1) : phase_reg - PH_W'(1);
            end else if (row_reg != '0) begin
                row_x = row_x - ROWX_W'(1);
                col_x = COLX_W'(NUM_COLUMNS - 1);
                ph_x  = PH_W'(LAST_PH);
            end
        end else if (char_code == tcw_pkg::CH_CR) begin
            col_x = '0;
            ph_x  = '0;
        end else if (char_code == tcw_pkg::CH_TAB) begin
            col_x = COLX_W'(col_reg) + COLX_W'(TAB_STOP) - COLX_W'(phase_reg);
            ph_x  = '0;
        end else if (printable) begin
            col_x = COLX_W'(col_reg) + COLX_W'(1);
            ph_x  = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0 : phase_reg + PH_W'(1);
        end else begin
            // Other control bytes and bytes from 0x80 up leave the cursor where it is.
            ph_x  = phase_reg;
        end

        if (col_x >= COLX_W'(NUM_COLUMNS)) begin
            col_x = '0;
            row_x = row_x + ROWX_W'(1);
            ph_x  = '0;
        end

        if (row_x >= ROWX_W'(NUM_ROWS)) begin
            row_x       = ROWX_W'(NUM_ROWS - 1);
            need_scroll = 1'b1;
        end
    end

    // Memory port control. The scroll copy reads one row ahead and writes
    // the cell fetched in the previous cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = sweep_reg;
        mem_raddr = ADDR_W'(cell_index);
        mem_wdata = {attr_reg, tcw_pkg::CH_SPACE};
        if (cmd.exec && is_write && printable) begin
            mem_we    = 1'b1;
            mem_waddr = cur_lin;
            mem_wdata = {attr_reg, char_code};
        end
        if (cmd.exec && (opcode == tcw_pkg::OP_READ) && idx_hit) begin
            mem_re = 1'b1;
        end
        if (cmd.prime) begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(NUM_COLUMNS);
        end
        if (cmd.scroll) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg - ADDR_W'(NUM_COLUMNS);
            mem_wdata = mem_q_reg;
            mem_re    = !sweep_last;
            mem_raddr = sweep_reg + ADDR_W'(1);
        end
        if (cmd.blank) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = {cmd.blank_init ? tcw_pkg::RESET_ATTR : attr_reg, tcw_pkg::CH_SPACE};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        phase_next   = phase_reg;
        attr_next    = cfg_wr_en ? cfg_wr_data : attr_reg;
        sweep_next   = sweep_reg;
        rd_hit_next  = rd_hit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_pos_next   = m_pos_reg;
        m_cell_next  = m_cell_reg;

        if (cmd.exec) begin
            rd_hit_next = (opcode == tcw_pkg::OP_READ) && idx_hit;
            if (is_write) begin
                col_next   = COL_W'(col_x);
                row_next   = ROW_W'(row_x);
                phase_next = ph_x;
            end else if (opcode == tcw_pkg::OP_CLEAR) begin
                col_next   = '0;
                row_next   = '0;
                phase_next = '0;
                sweep_next = '0;
            end
        end

        if (cmd.prime) begin
            sweep_next = ADDR_W'(NUM_COLUMNS);
        end
        if (cmd.scroll) begin
            sweep_next = sweep_last ? ADDR_W'(COPY_CELLS) : sweep_reg + ADDR_W'(1);
        end
        if (cmd.blank) begin
            sweep_next = sweep_last ? '0 : sweep_reg + ADDR_W'(1);
        end

        if (cmd.load_result) begin
            m_valid_next = 1'b1;
            m_pos_next   = tcw_pkg::POS_W'(cur_lin);
            m_cell_next  = rd_hit_reg ? mem_q_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            attr_reg    <= tcw_pkg::RESET_ATTR;
            sweep_reg   <= '0;
            rd_hit_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            phase_reg   <= phase_next;
            attr_reg    <= attr_next;
            sweep_reg   <= sweep_next;
            rd_hit_reg  <= rd_hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pos_reg  <= m_pos_next;
        m_cell_reg <= m_cell_next;
    end

    assign status.exec_scroll = is_write && need_scroll;
    assign status.exec_clear  = (opcode == tcw_pkg::OP_CLEAR);
    assign status.sweep_last  = sweep_last;
    assign status.out_free    = !m_valid_reg || m_tready;

    assign m_valid         = m_valid_reg;
    assign cursor_position = m_pos_reg;
    assign cell_value      = m_cell_reg;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller of the text console character writer: sequences the reset
// sweep, item execution, scroll copy, blanking and result hand-off.
// Depends on tcw_pkg; commands tcw_datapath.
module tcw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_PRIME  = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_BLANK  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.blank      = 1'b1;
                cmd.blank_init = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.exec = 1'b1;
                    priority if (status.exec_scroll) begin
                        state_next = ST_PRIME;
                    end else if (status.exec_clear) begin
                        state_next = ST_BLANK;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_PRIME: begin
                cmd.prime  = 1'b1;
                state_next = ST_SCROLL;
            end
            ST_SCROLL: begin
                cmd.scroll = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                cmd.blank = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // Wait here until the previous result has been taken.
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/text_console_char_writer.sv =====
// Channel   | Direction | Signals                         | Contents
// s_ items  | in        | s_tvalid s_tready s_tdata s_tuser | opcode, character, cell index
// m_ result | out       | m_tvalid m_tready m_tdata       | cursor position, cell value
// cfg       | in        | cfg_wr_en cfg_wr_data           | text attribute
//
// Write, read and unused opcodes are accepted, then loaded into the output register once it is free.
// A clear blanks the whole grid, and a write that scrolls first copies the rows up and then blanks
// the last row, the cell memory (one write and one read port) visiting one cell a cycle.
// After reset the grid is blanked with s_tready low; attribute writes are taken during that time.
// A result waiting on m_tready holds the next item in its result cycle.
// Top level of the text console character writer; depends on tcw_pkg,
// tcw_ctrl, tcw_datapath and the assertion macro header.
`include "text_console_char_writer_macros.svh"

module text_console_char_writer #(
    parameter int NUM_COLUMNS = 80,
    parameter int NUM_ROWS    = 25,
    parameter int TAB_STOP    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [1:0]  s_tuser,     // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [10:0] cursor_position, [26:11] cell_value, rest zero
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    tcw_pkg::tcw_cmd_t          cmd;
    tcw_pkg::tcw_status_t       status;
    logic [tcw_pkg::POS_W-1:0]  cursor_position;
    logic [tcw_pkg::CELL_W-1:0] cell_value;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS),
        .TAB_STOP    (TAB_STOP)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .opcode          (s_tuser),
        .char_code       (s_tdata[7:0]),
        .cell_index      (s_tdata[18:8]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .m_tready        (m_tready),
        .m_valid         (m_tvalid),
        .cursor_position (cursor_position),
        .cell_value      (cell_value)
    );

    assign m_tdata = {5'b0, cell_value, cursor_position};

    // While the input side is open the grid must not be swept or a result loaded.
    `TCW_ASSERT_IMPL(a_idle_means_no_sweep, aclk, aresetn, s_tready, !(cmd.blank || cmd.scroll || cmd.prime || cmd.load_result))
    // One item at a time: a transfer closes the input side for the next cycle.
    `TCW_ASSERT_NEXT(a_one_item_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A result is only loaded when the output register is empty or being emptied.
    `TCW_ASSERT_IMPL(a_result_slot_free, aclk, aresetn, cmd.load_result, !m_tvalid || m_tready)

endmodule
